/* sv/usd_pkg.sv */
// Package for the epoch-seconds to calendar converter.
// Holds the controller/datapath command types, state enum and calendar constants.
// No dependencies.
`timescale 1ns / 1ps

package usd_pkg;

  localparam logic [11:0] EPOCH_YEAR   = 12'd1970;
  localparam logic [1:0]  EPOCH_MOD4   = 2'd2;
  localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
  localparam logic [8:0]  EPOCH_MOD400 = 9'd370;

  localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // Each quotient is the shifted dividend times a rounded-up reciprocal of the odd
  // part of the divisor: 86400 = 675 * 2^7, 3600 = 225 * 2^4 and 60 = 15 * 2^2.
  localparam logic [25:0] DAY_RECIP  = 26'd50903317;
  localparam logic [13:0] HOUR_RECIP = 14'd9321;
  localparam logic [10:0] MIN_RECIP  = 11'd1093;

  localparam logic [3:0] MONTH_DEC = 4'd12;

  typedef enum logic [1:0] {
    PH_DAY,
    PH_HOUR,
    PH_MIN
  } div_phase_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DAY_QUOT,
    ST_DAY_REM,
    ST_HOUR_QUOT,
    ST_HOUR_REM,
    ST_MIN_QUOT,
    ST_MIN_REM,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } usd_state_t;

  typedef struct packed {
    logic       load;
    logic       div_quot;
    logic       div_rem;
    div_phase_t phase;
    logic       year_step;
    logic       month_step;
    logic       publish;
  } usd_cmd_t;

  typedef struct packed {
    logic year_more;
    logic month_more;
  } usd_status_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

/* sv/usd_datapath.sv */
// Datapath of the converter: reciprocal-multiply dividers, year and month walkers,
// and the result register. Depends on usd_pkg.
`timescale 1ns / 1ps

module usd_datapath (
  input  logic               clk,
  input  usd_pkg::usd_cmd_t  cmd,
  output usd_pkg::usd_status_t status,
  input  logic [31:0]        in_epoch_seconds,
  output logic [11:0]        out_year,
  output logic [3:0]         out_month,
  output logic [4:0]         out_day_of_month,
  output logic [4:0]         out_hour,
  output logic [5:0]         out_minute,
  output logic [5:0]         out_sec
);

  logic [31:0] rem_r, rem_nxt;
  logic [15:0] days_r, days_nxt;
  logic [4:0]  hour_r, hour_nxt;
  logic [5:0]  minute_r, minute_nxt;
  logic [11:0] year_r, year_nxt;
  logic [1:0]  mod4_r, mod4_nxt;
  logic [6:0]  mod100_r, mod100_nxt;
  logic [8:0]  mod400_r, mod400_nxt;
  logic [3:0]  month_r, month_nxt;

  logic [11:0] res_year_r;
  logic [3:0]  res_month_r;
  logic [4:0]  res_day_r;
  logic [4:0]  res_hour_r;
  logic [5:0]  res_minute_r;
  logic [5:0]  res_sec_r;

  logic [50:0] day_prod;
  logic [26:0] hour_prod;
  logic [20:0] min_prod;
  logic [31:0] day_back;
  logic [16:0] hour_back;
  logic [11:0] min_back;
  logic        leap;
  logic [8:0]  ylen;
  logic [4:0]  dim;

  assign day_prod  = 51'(rem_r[31:7]) * 51'(usd_pkg::DAY_RECIP);
  assign hour_prod = 27'(rem_r[16:4]) * 27'(usd_pkg::HOUR_RECIP);
  assign min_prod  = 21'(rem_r[11:2]) * 21'(usd_pkg::MIN_RECIP);
  assign day_back  = 32'(days_r) * 32'(usd_pkg::SECS_PER_DAY);
  assign hour_back = 17'(hour_r) * 17'(usd_pkg::SECS_PER_HOUR);
  assign min_back  = 12'(minute_r) * 12'(usd_pkg::SECS_PER_MIN);

  assign leap    = (mod400_r == 9'd0) || ((mod4_r == 2'd0) && (mod100_r != 7'd0));
  assign ylen    = leap ? 9'd366 : 9'd365;
  assign dim     = usd_pkg::month_len(month_r, leap);

  assign status.year_more  = days_r >= 16'(ylen);
  assign status.month_more = (days_r >= 16'(dim)) && (month_r != usd_pkg::MONTH_DEC);

  always_comb begin
    rem_nxt    = rem_r;
    days_nxt   = days_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    year_nxt   = year_r;
    mod4_nxt   = mod4_r;
    mod100_nxt = mod100_r;
    mod400_nxt = mod400_r;
    month_nxt  = month_r;
    if (cmd.load) begin
      rem_nxt    = in_epoch_seconds;
      year_nxt   = usd_pkg::EPOCH_YEAR;
      mod4_nxt   = usd_pkg::EPOCH_MOD4;
      mod100_nxt = usd_pkg::EPOCH_MOD100;
      mod400_nxt = usd_pkg::EPOCH_MOD400;
      month_nxt  = 4'd1;
    end
    if (cmd.div_quot) begin
      case (cmd.phase)
        usd_pkg::PH_DAY: begin
          days_nxt = day_prod[50:35];
        end
        usd_pkg::PH_HOUR: begin
          hour_nxt = hour_prod[25:21];
        end
        default: begin
          minute_nxt = min_prod[19:14];
        end
      endcase
    end
    if (cmd.div_rem) begin
      case (cmd.phase)
        usd_pkg::PH_DAY: begin
          rem_nxt = rem_r - day_back;
        end
        usd_pkg::PH_HOUR: begin
          rem_nxt = rem_r - 32'(hour_back);
        end
        default: begin
          rem_nxt = rem_r - 32'(min_back);
        end
      endcase
    end
    if (cmd.year_step) begin
      days_nxt   = days_r - 16'(ylen);
      year_nxt   = year_r + 12'd1;
      mod4_nxt   = mod4_r + 2'd1;
      mod100_nxt = (mod100_r == 7'd99) ? 7'd0 : mod100_r + 7'd1;
      mod400_nxt = (mod400_r == 9'd399) ? 9'd0 : mod400_r + 9'd1;
    end
    if (cmd.month_step) begin
      days_nxt  = days_r - 16'(dim);
      month_nxt = month_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    rem_r    <= rem_nxt;
    days_r   <= days_nxt;
    hour_r   <= hour_nxt;
    minute_r <= minute_nxt;
    year_r   <= year_nxt;
    mod4_r   <= mod4_nxt;
    mod100_r <= mod100_nxt;
    mod400_r <= mod400_nxt;
    month_r  <= month_nxt;
    if (cmd.publish) begin
      res_year_r   <= year_r;
      res_month_r  <= month_r;
      res_day_r    <= days_r[4:0] + 5'd1;
      res_hour_r   <= hour_r;
      res_minute_r <= minute_r;
      res_sec_r    <= rem_r[5:0];
    end
  end

  assign out_year         = res_year_r;
  assign out_month        = res_month_r;
  assign out_day_of_month = res_day_r;
  assign out_hour         = res_hour_r;
  assign out_minute       = res_minute_r;
  assign out_sec          = res_sec_r;

endmodule

/* sv/usd_ctrl.sv */
// Controller state machine of the converter: sequences the divider phases,
// the year and month walks and the result handshake. Depends on usd_pkg.
`timescale 1ns / 1ps

module usd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  usd_pkg::usd_status_t status,
  output usd_pkg::usd_cmd_t   cmd
);

  usd_pkg::usd_state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= usd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.phase     = usd_pkg::PH_DAY;
    in_ready      = 1'b0;
    case (state_r)
      usd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = usd_pkg::ST_DAY_QUOT;
        end
      end
      usd_pkg::ST_DAY_QUOT: begin
        cmd.div_quot = 1'b1;
        cmd.phase    = usd_pkg::PH_DAY;
        state_nxt    = usd_pkg::ST_DAY_REM;
      end
      usd_pkg::ST_DAY_REM: begin
        cmd.div_rem = 1'b1;
        cmd.phase   = usd_pkg::PH_DAY;
        state_nxt   = usd_pkg::ST_HOUR_QUOT;
      end
      usd_pkg::ST_HOUR_QUOT: begin
        cmd.div_quot = 1'b1;
        cmd.phase    = usd_pkg::PH_HOUR;
        state_nxt    = usd_pkg::ST_HOUR_REM;
      end
      usd_pkg::ST_HOUR_REM: begin
        cmd.div_rem = 1'b1;
        cmd.phase   = usd_pkg::PH_HOUR;
        state_nxt   = usd_pkg::ST_MIN_QUOT;
      end
      usd_pkg::ST_MIN_QUOT: begin
        cmd.div_quot = 1'b1;
        cmd.phase    = usd_pkg::PH_MIN;
        state_nxt    = usd_pkg::ST_MIN_REM;
      end
      usd_pkg::ST_MIN_REM: begin
        cmd.div_rem = 1'b1;
        cmd.phase   = usd_pkg::PH_MIN;
        state_nxt   = usd_pkg::ST_YEAR;
      end
      usd_pkg::ST_YEAR: begin
        if (status.year_more) begin
          cmd.year_step = 1'b1;
        end else begin
          state_nxt = usd_pkg::ST_MONTH;
        end
      end
      usd_pkg::ST_MONTH: begin
        if (status.month_more) begin
          cmd.month_step = 1'b1;
        end else begin
          state_nxt = usd_pkg::ST_DONE;
        end
      end
      usd_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = usd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = usd_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

/* sv/unix_seconds_to_date_core.sv */
// Top level of the epoch-seconds to calendar converter.
// Instantiates usd_ctrl and usd_datapath; depends on usd_pkg.
//
// Converts an unsigned 32-bit count of seconds since 1970-01-01 00:00:00 into
// year, month, day of month, hour, minute and second, with full Gregorian leap
// year rules. One request is worked on at a time. For the day count, the hour and
// the minute in turn, a multiplication by a scaled reciprocal gives the quotient and
// then a multiply-and-subtract leaves the remainder. Whole years are then removed
// one per cycle, followed by whole months one per cycle. A finished request waits
// until the previous result has been taken, and the next request is accepted in
// the cycle after the result is loaded. The result sits in an output register, so
// a new request is accepted while the previous result still waits to be taken.
`timescale 1ns / 1ps

module unix_seconds_to_date_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_epoch_seconds,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [11:0] out_year,
  output logic [3:0]  out_month,
  output logic [4:0]  out_day_of_month,
  output logic [4:0]  out_hour,
  output logic [5:0]  out_minute,
  output logic [5:0]  out_sec
);

  usd_pkg::usd_cmd_t    cmd;
  usd_pkg::usd_status_t status;

  usd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  usd_datapath u_datapath (
    .clk              (clk),
    .cmd              (cmd),
    .status           (status),
    .in_epoch_seconds (in_epoch_seconds),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_sec          (out_sec)
  );

endmodule

/* sv/usd_checker.sv */
// Port-level checker for unix_seconds_to_date_core, attached with bind.
// Depends only on the top level's ports.
`timescale 1ns / 1ps

module usd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] out_year,
  input logic [3:0]  out_month,
  input logic [4:0]  out_day_of_month,
  input logic [4:0]  out_hour,
  input logic [5:0]  out_minute,
  input logic [5:0]  out_sec
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("new request accepted while one is in progress");

  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12 && out_day_of_month >= 5'd1 &&
                   out_hour <= 5'd23 && out_minute <= 6'd59 && out_sec <= 6'd59 &&
                   out_year >= 12'd1970 && out_year <= 12'd2106))
    else $error("result field out of range");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_year) && $stable(out_month) &&
                                   $stable(out_day_of_month) && $stable(out_hour) &&
                                   $stable(out_minute) && $stable(out_sec)))
    else $error("stalled result changed");

endmodule

bind unix_seconds_to_date_core usd_checker u_usd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_year         (out_year),
  .out_month        (out_month),
  .out_day_of_month (out_day_of_month),
  .out_hour         (out_hour),
  .out_minute       (out_minute),
  .out_sec          (out_sec)
);

/* dv/tb_unix_seconds_to_date_core.sv */
// Testbench for unix_seconds_to_date_core: directed table then random requests, every
// result checked against typed table values or an in-bench calendar predictor, with random
// backpressure until the quiet phase. Depends only on the RTL of the converter.
`timescale 1ns / 1ps

module tb_unix_seconds_to_date_core;

  localparam int NumDirected = 23;
  localparam int NumRandom   = 700;
  localparam int HoldAt      = 200;
  localparam int PauseAt     = 400;
  localparam int QuietAt     = 600;
  localparam int HoldCycles  = 500;
  localparam int DrainCycles = 200;
  localparam int MaxPrinted  = 40;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day_of_month;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  sec;
  } cal_date_t;

  typedef struct packed {
    logic [31:0] secs;
    logic        typed;
    cal_date_t   date;
  } date_row_t;

  typedef struct packed {
    logic [31:0] secs;
    cal_date_t   date;
  } pending_date_t;

  logic        clk;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_ready;
  logic [31:0] in_epoch_seconds = '0;
  logic        out_valid;
  logic        out_ready        = 1'b0;
  logic [11:0] out_year;
  logic [3:0]  out_month;
  logic [4:0]  out_day_of_month;
  logic [4:0]  out_hour;
  logic [5:0]  out_minute;
  logic [5:0]  out_sec;

  pending_date_t pending_dates[$];
  int unsigned   error_count     = 0;
  int unsigned   requests_sent   = 0;
  int unsigned   results_checked = 0;
  bit            quiet_mode      = 1'b0;
  bit            long_hold_req   = 1'b0;

  date_row_t directed_rows [NumDirected] = '{
    '{32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd1,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd1}},
    '{32'd59,         1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd59}},
    '{32'd60,         1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd1,  6'd0}},
    '{32'd3599,       1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd59, 6'd59}},
    '{32'd3600,       1'b1, '{12'd1970, 4'd1,  5'd1,  5'd1,  6'd0,  6'd0}},
    '{32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
    '{32'd86400,      1'b1, '{12'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0}},
    '{32'd2678400,    1'b1, '{12'd1970, 4'd2,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd31535999,   1'b1, '{12'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{32'd31536000,   1'b1, '{12'd1971, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd68169600,   1'b0, '0},
    '{32'd94694399,   1'b0, '0},
    '{32'd94694400,   1'b0, '0},
    '{32'd946684799,  1'b0, '0},
    '{32'd951782400,  1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'd2147483647, 1'b0, '0},
    '{32'd2147483648, 1'b0, '0},
    '{32'hAAAA_AAAA,  1'b0, '0},
    '{32'h5555_5555,  1'b0, '0},
    '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15}}
  };

  unix_seconds_to_date_core i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_epoch_seconds (in_epoch_seconds),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_year         (out_year),
    .out_month        (out_month),
    .out_day_of_month (out_day_of_month),
    .out_hour         (out_hour),
    .out_minute       (out_minute),
    .out_sec          (out_sec)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(6_000_000);
    $display("unix_seconds_to_date_core: mismatch");
    $finish;
  end

  function automatic bit is_leap(input int unsigned year);
    return (year % 400 == 0) || ((year % 4 == 0) && (year % 100 != 0));
  endfunction

  function automatic int unsigned month_length(input int unsigned year, input int unsigned month);
    int unsigned len;
    case (month)
      2:             len = is_leap(year) ? 29 : 28;
      4, 6, 9, 11:   len = 30;
      default:       len = 31;
    endcase
    return len;
  endfunction

  function automatic longint month_start_seconds(input int unsigned year,
                                                 input int unsigned month);
    longint days;
    days = 0;
    for (int unsigned y = 1970; y < year; y++) days += is_leap(y) ? 366 : 365;
    for (int unsigned m = 1; m < month; m++) days += month_length(year, m);
    return days * 86400;
  endfunction

  function automatic cal_date_t to_calendar(input logic [31:0] secs);
    int unsigned total;
    int unsigned days;
    int unsigned tod;
    int unsigned year;
    int unsigned month;
    cal_date_t   date;
    total = secs;
    days  = total / 86400;
    tod   = total % 86400;
    date.hour   = 5'(tod / 3600);
    date.minute = 6'((tod % 3600) / 60);
    date.sec    = 6'(tod % 60);
    year = 1970;
    while (days >= (is_leap(year) ? 366 : 365)) begin
      days -= is_leap(year) ? 366 : 365;
      year++;
    end
    month = 1;
    while (month != 12 && days >= month_length(year, month)) begin
      days -= month_length(year, month);
      month++;
    end
    date.year         = 12'(year);
    date.month        = 4'(month);
    date.day_of_month = 5'(days + 1);
    return date;
  endfunction

  task automatic report_mismatch(input logic [31:0] secs, input string what,
                                 input int unsigned got, input int unsigned want);
    error_count++;
    if (error_count <= MaxPrinted) begin
      $display("%0t ns: seconds %0d: %s got %0d, expected %0d", $time, secs, what, got, want);
    end
  endtask

  task automatic send_request(input logic [31:0] secs, input cal_date_t want);
    in_valid         <= 1'b1;
    in_epoch_seconds <= secs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_dates.push_back('{secs, want});
    requests_sent++;
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic check_result();
    pending_date_t oldest;
    if (pending_dates.size() == 0) begin
      report_mismatch('0, "result with no request pending, year", out_year, 0);
    end else begin
      oldest = pending_dates.pop_front();
      results_checked++;
      if (out_year !== oldest.date.year)
        report_mismatch(oldest.secs, "year", out_year, oldest.date.year);
      if (out_month !== oldest.date.month)
        report_mismatch(oldest.secs, "month", out_month, oldest.date.month);
      if (out_day_of_month !== oldest.date.day_of_month)
        report_mismatch(oldest.secs, "day_of_month", out_day_of_month,
                        oldest.date.day_of_month);
      if (out_hour !== oldest.date.hour)
        report_mismatch(oldest.secs, "hour", out_hour, oldest.date.hour);
      if (out_minute !== oldest.date.minute)
        report_mismatch(oldest.secs, "minute", out_minute, oldest.date.minute);
      if (out_sec !== oldest.date.sec)
        report_mismatch(oldest.secs, "sec", out_sec, oldest.date.sec);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_result();
    end
  end

  // The long hold keeps out_ready low so the output register and the datapath
  // both fill and the converter stops taking requests.
  initial begin
    wait (rst_n);
    forever begin
      if (long_hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        long_hold_req = 1'b0;
      end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin
    logic [31:0] secs;
    longint      near;
    int unsigned pick;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_request(directed_rows[i].secs, directed_rows[i].typed ?
                   directed_rows[i].date : to_calendar(directed_rows[i].secs));
    end

    for (int n = 0; n < NumRandom; n++) begin
      if (n == HoldAt) long_hold_req = 1'b1;
      if (n == PauseAt) begin
        in_valid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge clk);
      end
      if (n == QuietAt) quiet_mode = 1'b1;
      pick = $urandom_range(0, 9);
      if (pick <= 3) begin
        secs = $urandom;
      end else if (pick <= 6) begin
        near = month_start_seconds($urandom_range(1970, 2106), $urandom_range(1, 12)) +
               longint'($urandom_range(0, 4)) - 2;
        secs = (near < 0 || near > 64'hFFFF_FFFF) ? $urandom : 32'(near);
      end else if (pick == 7) begin
        secs = $urandom_range(0, 49709) * 32'd86400 + $urandom_range(0, 86399);
      end else if (pick == 8) begin
        secs = $urandom_range(0, 40_000_000);
      end else begin
        secs = 32'hF000_0000 | $urandom;
      end
      send_request(secs, to_calendar(secs));
    end

    in_valid <= 1'b0;
    while (pending_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Converted %0d requests (%0d from the directed table), checked %0d results.",
             requests_sent, NumDirected, results_checked);
    $display("Covered day, month and year boundaries, leap days, a long output stall and a drain pause; %0d field errors.",
             error_count);
    if (error_count == 0) begin
      $display("unix_seconds_to_date_core: match");
    end else begin
      $display("unix_seconds_to_date_core: mismatch");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/usd_pkg.sv
sv/usd_datapath.sv
sv/usd_ctrl.sv
sv/unix_seconds_to_date_core.sv
sv/usd_checker.sv
dv/tb_unix_seconds_to_date_core.sv
